### rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants of the ultrasonic echo ranger: register map,
// reset values, controller phase and status codes, and the distance constant.
// ----------------------------------------------------------------------------
package uer_pkg;

	// register indexes on the configuration port
	localparam int unsigned CfgIdxW = 3;
	localparam logic [CfgIdxW-1:0] REG_TIMEOUT = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_SETTLE  = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_TRIGGER = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_MIN     = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_MAX     = 3'd4;

	localparam int unsigned CfgDataW = 16;
	localparam int unsigned UsW      = 17;

	// register reset values
	localparam logic [15:0] TIMEOUT_RST = 16'd30000;
	localparam logic [15:0] SETTLE_RST  = 16'd2000;
	localparam logic [7:0]  TRIGGER_RST = 8'd10;
	localparam logic [15:0] MIN_RST     = 16'd116;
	localparam logic [15:0] MAX_RST     = 16'd23200;

	// controller phases
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_SETTLE = 3'd1;
	localparam logic [2:0] PH_TRIG   = 3'd2;
	localparam logic [2:0] PH_WAIT   = 3'd3;
	localparam logic [2:0] PH_ECHO   = 3'd4;

	// measurement status
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_RISE  = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;
	localparam logic [1:0] ST_RANGE    = 2'd3;

	// distance = floor(us*64/58) = floor(us*32/29) = floor(us * RECIP / 2^21),
	// RECIP = ceil(2^26/29); exact for us up to 2^16 (error term 7*2^21 < 2^26)
	localparam int unsigned RecipW   = 22;
	localparam int unsigned RecipSh  = 21;
	localparam logic [RecipW-1:0] RECIP = 22'd2314099;

	typedef struct packed {
		logic [15:0] max_wait_us;
		logic [15:0] settle_us;
		logic [7:0]  trigger_us;
		logic [15:0] min_echo_us;
		logic [15:0] max_echo_us;
	} cfg_t;

	typedef struct packed {
		logic           trigger_out;
		logic           done_res;
		logic           valid_res;
		logic [1:0]     status;
		logic [UsW-1:0] echo_us;
	} ctrl_res_t;

endpackage

### rtl/uer_ctrl.sv
// ----------------------------------------------------------------------------
// uer_ctrl
// Trigger / echo phase machine. Each accepted word is one microsecond tick;
// the machine advances once per accepted word and gives that tick's result.
// ----------------------------------------------------------------------------
module uer_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tick,
	input  logic               start_req,
	input  logic               echo_level,
	input  uer_pkg::cfg_t      cfg,
	output uer_pkg::ctrl_res_t res
);

	logic [2:0]                   phase_q, phase_d;
	logic [uer_pkg::UsW-1:0]      tick_q, tick_d, tick_inc;
	logic [uer_pkg::UsW-1:0]      timeout_x;

	assign tick_inc  = tick_q + 17'd1;
	assign timeout_x = {1'b0, cfg.max_wait_us};

	// next phase and result of this tick
	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		res     = '0;
		unique case (phase_q)
			uer_pkg::PH_SETTLE: begin
				tick_d = tick_inc;
				if (tick_inc >= {1'b0, cfg.settle_us}) begin
					phase_d = uer_pkg::PH_TRIG;
					tick_d  = '0;
				end
			end
			uer_pkg::PH_TRIG: begin
				res.trigger_out = 1'b1;
				tick_d = tick_inc;
				if (tick_inc >= {9'd0, cfg.trigger_us}) begin
					phase_d = uer_pkg::PH_WAIT;
					tick_d  = '0;
				end
			end
			uer_pkg::PH_WAIT: begin
				if (echo_level) begin
					phase_d = uer_pkg::PH_ECHO;
					tick_d  = 17'd1;
					// zero timeout: a single high tick already overruns
					if (cfg.max_wait_us == 16'd0) begin
						res.done_res = 1'b1;
						res.status   = uer_pkg::ST_TOO_LONG;
						res.echo_us  = 17'd1;
						phase_d      = uer_pkg::PH_IDLE;
						tick_d       = '0;
					end
				end else begin
					tick_d = tick_inc;
					if (tick_inc > timeout_x) begin
						res.done_res = 1'b1;
						res.status   = uer_pkg::ST_NO_RISE;
						phase_d      = uer_pkg::PH_IDLE;
						tick_d       = '0;
					end
				end
			end
			uer_pkg::PH_ECHO: begin
				if (echo_level) begin
					tick_d = tick_inc;
					if (tick_inc > timeout_x) begin
						res.done_res = 1'b1;
						res.status   = uer_pkg::ST_TOO_LONG;
						res.echo_us  = tick_inc;
						phase_d      = uer_pkg::PH_IDLE;
						tick_d       = '0;
					end
				end else begin
					// falling edge: range-check the pulse
					res.done_res = 1'b1;
					res.echo_us  = tick_q;
					if (tick_q < {1'b0, cfg.min_echo_us} ||
					    tick_q > {1'b0, cfg.max_echo_us}) begin
						res.status = uer_pkg::ST_RANGE;
					end else begin
						res.status    = uer_pkg::ST_OK;
						res.valid_res = 1'b1;
					end
					phase_d = uer_pkg::PH_IDLE;
					tick_d  = '0;
				end
			end
			default: begin
				phase_d = uer_pkg::PH_IDLE;
				if (start_req) begin
					phase_d = (cfg.settle_us == 16'd0) ? uer_pkg::PH_TRIG
					                                   : uer_pkg::PH_SETTLE;
					tick_d  = '0;
				end
			end
		endcase
	end

	// advance on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= uer_pkg::PH_IDLE;
			tick_q  <= '0;
		end else if (tick) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
		end
	end

endmodule

### rtl/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Ultrasonic rangefinder trigger / echo controller with distance output.
// ----------------------------------------------------------------------------
// Every input word is one microsecond tick and yields exactly one output word.
// The block takes one word per clock cycle while in_stall is low. A result is
// registered in the first stage, which runs the phase machine, and again in
// the second, which turns the pulse length into 1/64 cm with one reciprocal
// multiply. A stall on a waiting output word freezes both stages and is
// passed back as in_stall. Configuration registers are written directly and
// act on the next tick.
module ultrasonic_echo_ranger (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration port
	input  logic                            cfg_wr,
	input  logic [uer_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [uer_pkg::CfgDataW-1:0]    cfg_data,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            start_req,
	input  logic                            echo_level,
	// output channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            trigger_out,
	output logic                            done_res,
	output logic                            valid_res,
	output logic [1:0]                      status,
	output logic [uer_pkg::UsW-1:0]         echo_us,
	output logic [uer_pkg::UsW-1:0]         distance_q6
);

	uer_pkg::cfg_t      cfg_q;
	uer_pkg::ctrl_res_t res;
	uer_pkg::ctrl_res_t res_s1, res_s2;
	logic               valid_s1, valid_s2;
	logic               advance, accept;
	logic [uer_pkg::UsW-1:0]                    dist_s2;
	logic [uer_pkg::UsW+uer_pkg::RecipW-1:0]    prod;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_wait_us <= uer_pkg::TIMEOUT_RST;
			cfg_q.settle_us   <= uer_pkg::SETTLE_RST;
			cfg_q.trigger_us  <= uer_pkg::TRIGGER_RST;
			cfg_q.min_echo_us <= uer_pkg::MIN_RST;
			cfg_q.max_echo_us <= uer_pkg::MAX_RST;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				uer_pkg::REG_TIMEOUT: cfg_q.max_wait_us <= cfg_data;
				uer_pkg::REG_SETTLE:  cfg_q.settle_us   <= cfg_data;
				uer_pkg::REG_TRIGGER: cfg_q.trigger_us  <= cfg_data[7:0];
				uer_pkg::REG_MIN:     cfg_q.min_echo_us <= cfg_data;
				uer_pkg::REG_MAX:     cfg_q.max_echo_us <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline moves whenever the output slot is free or being taken
	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = !advance;
	assign accept   = in_valid && advance;

	uer_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick       (accept),
		.start_req  (start_req),
		.echo_level (echo_level),
		.cfg        (cfg_q),
		.res        (res)
	);

	// stage 1: phase machine result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	// stage 2: distance by reciprocal multiply
	assign prod = uer_pkg::UsW'(res_s1.echo_us) * uer_pkg::RECIP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2  <= res_s1;
			dist_s2 <= prod[uer_pkg::RecipSh +: uer_pkg::UsW];
		end
	end

	assign out_valid   = valid_s2;
	assign trigger_out = res_s2.trigger_out;
	assign done_res    = res_s2.done_res;
	assign valid_res   = res_s2.valid_res;
	assign status      = res_s2.status;
	assign echo_us     = res_s2.echo_us;
	assign distance_q6 = dist_s2;

	// a good measurement is a finished one with status ok
	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |-> done_res && status == uer_pkg::ST_OK)
		else $error("valid_res without finished ok measurement");

	// ticks that finish nothing carry an empty result
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> echo_us == '0 && distance_q6 == '0 &&
		status == uer_pkg::ST_OK && !valid_res)
		else $error("non-final tick carries result data");

	// the trigger pulse never overlaps a finishing tick
	a_trig_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && trigger_out |-> !done_res)
		else $error("trigger high on finishing tick");

	// an accepted word reaches the output stage once the pipe moves again
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> valid_s2)
		else $error("stage 1 word lost");

endmodule

### sim/uer_range_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_range_checker
// Watches the tick and result channels of the echo ranger, predicts every
// result word from its own copy of the phase machine and registers, and
// compares each result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module uer_range_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr,
	input  logic [uer_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [uer_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic                          start_req,
	input  logic                          echo_level,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic                          trigger_out,
	input  logic                          done_res,
	input  logic                          valid_res,
	input  logic [1:0]                    status,
	input  logic [uer_pkg::UsW-1:0]       echo_us,
	input  logic [uer_pkg::UsW-1:0]       distance_q6,
	output int                            n_fail,
	output int                            pending,
	output logic [2:0]                    phase_now
);

	// round trip time of sound per centimeter, and fraction bits of the distance
	localparam int unsigned US_PER_CM = 58;
	localparam int unsigned FRAC_BITS = 6;

	typedef struct packed {
		logic                    trig;
		logic                    done;
		logic                    ok;
		logic [1:0]              st;
		logic [uer_pkg::UsW-1:0] us;
		logic [uer_pkg::UsW-1:0] dq6;
	} tick_word_t;

	tick_word_t              expected_ticks[$];
	uer_pkg::cfg_t           regs;
	logic [2:0]              ph;
	logic [uer_pkg::UsW-1:0] cnt;
	int                      words_seen;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: result word %0d: %s", $time, words_seen, msg);
		n_fail++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, want));
	endtask

	// close a measurement: report it and return to idle
	function automatic tick_word_t end_measure(input logic [1:0] st,
			input logic [uer_pkg::UsW-1:0] us);
		tick_word_t                        r;
		logic [uer_pkg::UsW+FRAC_BITS-1:0] scaled;
		scaled = {us, {FRAC_BITS{1'b0}}};
		r = '0;
		r.done = 1'b1;
		r.ok = (st == uer_pkg::ST_OK);
		r.st = st;
		r.us = us;
		r.dq6 = uer_pkg::UsW'(scaled / US_PER_CM);
		ph = uer_pkg::PH_IDLE;
		cnt = '0;
		return r;
	endfunction

	// advance the phase machine by one microsecond tick
	function automatic tick_word_t range_tick(input logic s, input logic e);
		tick_word_t r;
		r = '0;
		case (ph)
			uer_pkg::PH_SETTLE: begin
				cnt = cnt + 1'b1;
				if (cnt >= regs.settle_us) begin
					ph = uer_pkg::PH_TRIG;
					cnt = '0;
				end
			end
			uer_pkg::PH_TRIG: begin
				r.trig = 1'b1;
				cnt = cnt + 1'b1;
				if (cnt >= regs.trigger_us) begin
					ph = uer_pkg::PH_WAIT;
					cnt = '0;
				end
			end
			uer_pkg::PH_WAIT: begin
				if (e) begin
					ph = uer_pkg::PH_ECHO;
					cnt = uer_pkg::UsW'(1);
					if (cnt > regs.max_wait_us)
						r = end_measure(uer_pkg::ST_TOO_LONG, cnt);
				end else begin
					cnt = cnt + 1'b1;
					if (cnt > regs.max_wait_us)
						r = end_measure(uer_pkg::ST_NO_RISE, '0);
				end
			end
			uer_pkg::PH_ECHO: begin
				if (e) begin
					cnt = cnt + 1'b1;
					if (cnt > regs.max_wait_us)
						r = end_measure(uer_pkg::ST_TOO_LONG, cnt);
				end else begin
					r = end_measure((cnt < regs.min_echo_us || cnt > regs.max_echo_us) ?
						uer_pkg::ST_RANGE : uer_pkg::ST_OK, cnt);
				end
			end
			default: begin
				ph = uer_pkg::PH_IDLE;
				if (s) begin
					ph = (regs.settle_us == 0) ? uer_pkg::PH_TRIG : uer_pkg::PH_SETTLE;
					cnt = '0;
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tick_word_t want;
		if (!arst_n) begin
			regs = {uer_pkg::TIMEOUT_RST, uer_pkg::SETTLE_RST, uer_pkg::TRIGGER_RST,
				uer_pkg::MIN_RST, uer_pkg::MAX_RST};
			ph = uer_pkg::PH_IDLE;
			cnt = '0;
			expected_ticks.delete();
			words_seen = 0;
			n_fail = 0;
		end else begin
			// predict the accepted tick with the settings it saw
			if (in_valid && !in_stall)
				expected_ticks.push_back(range_tick(start_req, echo_level));

			// register writes act from the next tick on
			if (cfg_wr) begin
				case (cfg_index)
					uer_pkg::REG_TIMEOUT: regs.max_wait_us = cfg_data;
					uer_pkg::REG_SETTLE:  regs.settle_us = cfg_data;
					uer_pkg::REG_TRIGGER: regs.trigger_us = cfg_data[7:0];
					uer_pkg::REG_MIN:     regs.min_echo_us = cfg_data;
					uer_pkg::REG_MAX:     regs.max_echo_us = cfg_data;
					default: ;
				endcase
			end

			// compare the accepted result word
			if (out_valid && !out_stall) begin
				if (expected_ticks.size() == 0) begin
					report_mismatch("result word arrived with no tick outstanding");
				end else begin
					want = expected_ticks.pop_front();
					check_field("trigger_out", trigger_out, want.trig);
					check_field("done_res", done_res, want.done);
					check_field("valid_res", valid_res, want.ok);
					check_field("status", status, want.st);
					check_field("echo_us", echo_us, want.us);
					check_field("distance_q6", distance_q6, want.dq6);
				end
				words_seen++;
			end
		end
		pending = expected_ticks.size();
		phase_now = ph;
	end

endmodule

### sim/ultrasonic_echo_ranger_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_tb
// Drives microsecond ticks into the echo ranger: a short directed set that
// hits every status, then well-formed measurements with random timing mixed
// with noise, across several register settings. Input bursts and output
// stalls are random, with one long output hold-off that backs up the block.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_tb;

	localparam int WATCHDOG_NS   = 5_000_000;
	localparam int HOLD_CYCLES   = 300;
	localparam int ECHO_CAP      = 150;
	localparam int PHASE_TICKS   = 100;
	localparam int N_PHASES      = 10;
	localparam int PRESSURE_PH   = 5;
	localparam int STEADY_PH     = 6;
	localparam logic [uer_pkg::CfgIdxW-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [uer_pkg::CfgIdxW-1:0] REG_SPARE_HI = 3'd7;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         cfg_wr;
	logic [uer_pkg::CfgIdxW-1:0]  cfg_index;
	logic [uer_pkg::CfgDataW-1:0] cfg_data;
	logic                         in_valid;
	logic                         in_stall;
	logic                         start_req;
	logic                         echo_level;
	logic                         out_valid;
	logic                         out_stall;
	logic                         trigger_out;
	logic                         done_res;
	logic                         valid_res;
	logic [1:0]                   status;
	logic [uer_pkg::UsW-1:0]      echo_us;
	logic [uer_pkg::UsW-1:0]      distance_q6;

	int         n_fail;
	int         pending;
	logic [2:0] phase_now;

	int ticks_sent;
	int burst_left;
	bit gaps_on;
	int hold_asked;
	int hold_served;
	int cur_tmo;
	int cur_min;
	int cur_max;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ultrasonic_echo_ranger u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr      (cfg_wr),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.start_req   (start_req),
		.echo_level  (echo_level),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.trigger_out (trigger_out),
		.done_res    (done_res),
		.valid_res   (valid_res),
		.status      (status),
		.echo_us     (echo_us),
		.distance_q6 (distance_q6)
	);

	uer_range_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr      (cfg_wr),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.start_req   (start_req),
		.echo_level  (echo_level),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.trigger_out (trigger_out),
		.done_res    (done_res),
		.valid_res   (valid_res),
		.status      (status),
		.echo_us     (echo_us),
		.distance_q6 (distance_q6),
		.n_fail      (n_fail),
		.pending     (pending),
		.phase_now   (phase_now)
	);

	function automatic logic coin();
		return 1'($urandom_range(0, 1));
	endfunction

	// offer one tick word, with an optional gap ahead of a new burst
	task automatic send_tick(input logic s, input logic e);
		int gap;
		if (gaps_on && burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(0, 4);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		start_req <= s;
		echo_level <= e;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		ticks_sent++;
		@(negedge clk);
	endtask

	// finish any measurement, drop valid and let every result come out
	task automatic drain();
		while (phase_now != uer_pkg::PH_IDLE)
			send_tick(1'b0, 1'b0);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [uer_pkg::CfgIdxW-1:0] idx,
			input logic [uer_pkg::CfgDataW-1:0] val);
		cfg_wr <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr <= 1'b0;
		@(negedge clk);
	endtask

	// load all registers; junk in the upper trigger byte and a spare index must be dropped
	task automatic load_setting(input int tmo, input int st, input int tr, input int mn,
			input int mx);
		write_reg(uer_pkg::REG_TIMEOUT, tmo[15:0]);
		write_reg(uer_pkg::REG_SETTLE, st[15:0]);
		write_reg(uer_pkg::REG_TRIGGER, {8'($urandom), tr[7:0]});
		write_reg(uer_pkg::REG_MIN, mn[15:0]);
		write_reg(uer_pkg::REG_MAX, mx[15:0]);
		write_reg(uer_pkg::CfgIdxW'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
			uer_pkg::CfgDataW'($urandom));
		cur_tmo = tmo;
		cur_min = mn;
		cur_max = mx;
	endtask

	// one measurement: start, ride out settle and trigger, then wait and echo
	task automatic run_measure(input int wait_len, input int echo_len);
		int n;
		while (phase_now != uer_pkg::PH_IDLE)
			send_tick(coin(), coin());
		send_tick(1'b1, coin());
		while (phase_now == uer_pkg::PH_SETTLE || phase_now == uer_pkg::PH_TRIG)
			send_tick(coin(), coin());
		for (n = 0; n < wait_len && phase_now == uer_pkg::PH_WAIT; n++)
			send_tick(coin(), 1'b0);
		for (n = 0; n < echo_len && phase_now != uer_pkg::PH_IDLE; n++)
			send_tick(coin(), 1'b1);
		while (phase_now != uer_pkg::PH_IDLE)
			send_tick(coin(), 1'b0);
	endtask

	function automatic int pick_wait_len();
		if ($urandom_range(0, 7) == 0 && cur_tmo <= ECHO_CAP)
			return cur_tmo + 2;
		return $urandom_range(0, (cur_tmo < 8) ? cur_tmo : 8);
	endfunction

	// echo length: mostly in the window, some short, long and timed out
	function automatic int pick_echo_len();
		int cap;
		int lo;
		int hi;
		int sel;
		cap = (cur_tmo < ECHO_CAP) ? cur_tmo : ECHO_CAP;
		lo = (cur_min > 1) ? cur_min : 1;
		hi = (cur_max < cap) ? cur_max : cap;
		sel = $urandom_range(0, 9);
		if (sel < 5 && lo <= hi)
			return $urandom_range(lo, hi);
		if (sel == 5 && cur_min > 1)
			return $urandom_range(1, cur_min - 1);
		if (sel == 6 && cur_max < cap)
			return $urandom_range(cur_max + 1, cap);
		if (sel == 7 && cur_tmo <= ECHO_CAP)
			return cur_tmo + 1 + $urandom_range(0, 2);
		return $urandom_range(1, cap + 2);
	endfunction

	// receiver: segments of random stall patterns, plus long hold-offs on request
	initial begin
		stall_mode_t mode;
		int          seg;
		int          k;
		out_stall = 1'b0;
		hold_served = 0;
		k = 0;
		forever begin
			if (hold_asked != hold_served) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_served++;
			end
			seg = $urandom_range(10, 120);
			mode = stall_mode_t'($urandom_range(0, 3));
			repeat (seg) begin
				case (mode)
					STALL_NONE:     out_stall <= 1'b0;
					STALL_LIGHT:    out_stall <= ($urandom_range(0, 7) == 0);
					STALL_HEAVY:    out_stall <= coin();
					STALL_PERIODIC: out_stall <= (k % 3 == 0);
					default:        out_stall <= 1'b0;
				endcase
				k++;
				@(negedge clk);
			end
		end
	end

	initial begin
		#(WATCHDOG_NS);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int p;
		int budget;
		int tmo;
		int mn;
		arst_n = 1'b0;
		cfg_wr = 1'b0;
		cfg_index = uer_pkg::REG_TIMEOUT;
		cfg_data = '0;
		in_valid = 1'b0;
		start_req = 1'b0;
		echo_level = 1'b0;
		ticks_sent = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		hold_asked = 0;
		cur_tmo = uer_pkg::TIMEOUT_RST;
		cur_min = uer_pkg::MIN_RST;
		cur_max = uer_pkg::MAX_RST;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// idle ticks under reset settings: echo alone must do nothing
		repeat (3) send_tick(1'b0, coin());
		drain();

		// directed: zero settle, zero trigger width, window of exactly 2 us
		load_setting(3, 0, 0, 2, 2);
		run_measure(0, 2);
		run_measure(1, 1);
		run_measure(0, 3);
		run_measure(2, 5);
		run_measure(9, 0);
		drain();

		// random measurements across settings, extremes first
		for (p = 0; p < N_PHASES; p++) begin
			case (p)
				0: load_setting(0, 0, 0, 0, 0);
				1: load_setting(65535, 1, 255, 0, 65535);
				2: load_setting(1, 2, 1, 1, 1);
				default: begin
					tmo = $urandom_range(1, 90);
					mn = $urandom_range(0, tmo / 2);
					load_setting(tmo, $urandom_range(0, 6), $urandom_range(0, 5), mn,
						$urandom_range(mn, tmo + 8));
				end
			endcase
			gaps_on = (p != PRESSURE_PH && p != STEADY_PH);
			if (p == PRESSURE_PH)
				hold_asked++;
			budget = ticks_sent + PHASE_TICKS;
			while (ticks_sent < budget) begin
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(1, 12)) send_tick(coin(), coin());
				else
					run_measure(pick_wait_len(), pick_echo_len());
			end
			drain();
		end

		if (n_fail == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### files.f
rtl/uer_pkg.sv
rtl/uer_ctrl.sv
rtl/ultrasonic_echo_ranger.sv
sim/uer_range_checker.sv
sim/ultrasonic_echo_ranger_tb.sv
